// ===== rtl/png_scanline_unfilter_core_defines.svh =====
// ---------------------------------------------------------------------------
// png scan-line unfilter assertion macros
// shared assertion shorthands for the unfilter checker
// ---------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define PSUF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked in the cycle after the trigger
`define PSUF_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/psuf_pkg.sv =====
// ---------------------------------------------------------------------------
// psuf_pkg
// types, constants and helpers of the png scan-line unfilter
// ---------------------------------------------------------------------------
`default_nettype none

package psuf_pkg;

  localparam int LINE_MAX    = 4096;
  localparam int PIXEL_MAX   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int LEN_W   = $clog2(LINE_MAX + 1);
  localparam int IDX_W   = $clog2(LINE_MAX);
  localparam int BPP_W   = 3;
  localparam int PIX_W   = $clog2(PIXEL_MAX);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LINE_MAX);
  localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(PIXEL_MAX);

  localparam logic REG_BYTES_PER_LINE  = 1'b0;
  localparam logic REG_BYTES_PER_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  localparam logic [7:0] FILTER_CODE_MAX = 8'(FILT_PAETH);

  typedef enum logic [1:0] {
    KIND_FILTER     = 2'd0,
    KIND_BAD_FILTER = 2'd1,
    KIND_DATA       = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [7:0]       value;
    filter_t          filter;
    logic [IDX_W-1:0] idx;
    logic             first_row;
    logic             last;
  } queue_entry_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psuf_if.sv =====
// ---------------------------------------------------------------------------
// psuf stream interfaces
// byte input and reconstructed byte output channels
// ---------------------------------------------------------------------------
`default_nettype none

interface psuf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_image;

  modport source (output valid, output byte_value, output start_image, input ready);
  modport sink   (input valid, input byte_value, input start_image, output ready);
endinterface

interface psuf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_in_row;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output last_in_row, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input last_in_row, input bad_filter,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/psuf_front.sv =====
// ---------------------------------------------------------------------------
// psuf_front
// accepts input bytes, tracks row position and classifies each transaction
// ---------------------------------------------------------------------------
`default_nettype none

module psuf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  psuf_byte_if.sink                        byte_in,
  input  wire logic [psuf_pkg::LEN_W-1:0]  line_len,
  input  wire logic                        q_ready,
  output logic                             q_push,
  output psuf_pkg::queue_entry_t           q_entry
);

  logic [psuf_pkg::LEN_W-1:0] byte_position;
  logic [psuf_pkg::LEN_W-1:0] byte_position_next;
  psuf_pkg::filter_t          row_filter;
  psuf_pkg::filter_t          row_filter_next;
  logic                       first_row;
  logic                       first_row_next;

  logic [psuf_pkg::LEN_W-1:0] pos_eff;
  logic [psuf_pkg::LEN_W-1:0] idx_full;
  logic                       first_eff;
  logic                       is_last;

  assign byte_in.ready = q_ready;
  assign q_push        = byte_in.valid && q_ready;

  assign pos_eff   = byte_in.start_image ? '0 : byte_position;
  assign first_eff = byte_in.start_image ? 1'b1 : first_row;
  assign idx_full  = pos_eff - psuf_pkg::LEN_W'(1);
  assign is_last   = (pos_eff >= line_len);

  always_comb begin
    byte_position_next = byte_position;
    row_filter_next    = row_filter;
    first_row_next     = first_row;
    q_entry.value      = byte_in.byte_value;
    q_entry.filter     = row_filter;
    q_entry.idx        = idx_full[psuf_pkg::IDX_W-1:0];
    q_entry.first_row  = first_eff;
    q_entry.last       = 1'b0;
    q_entry.kind       = psuf_pkg::KIND_DATA;
    if (pos_eff == '0) begin
      byte_position_next = psuf_pkg::LEN_W'(1);
      first_row_next     = first_eff;
      if (byte_in.byte_value > psuf_pkg::FILTER_CODE_MAX) begin
        q_entry.kind    = psuf_pkg::KIND_BAD_FILTER;
        row_filter_next = psuf_pkg::FILT_NONE;
      end else begin
        q_entry.kind    = psuf_pkg::KIND_FILTER;
        row_filter_next = psuf_pkg::filter_t'(byte_in.byte_value[2:0]);
      end
    end else begin
      q_entry.last = is_last;
      if (is_last) begin
        byte_position_next = '0;
        first_row_next     = 1'b0;
      end else begin
        byte_position_next = pos_eff + psuf_pkg::LEN_W'(1);
        first_row_next     = first_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_filter    <= psuf_pkg::FILT_NONE;
      first_row     <= 1'b1;
    end else if (q_push) begin
      byte_position <= byte_position_next;
      row_filter    <= row_filter_next;
      first_row     <= first_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psuf_queue.sv =====
// ---------------------------------------------------------------------------
// psuf_queue
// short fifo that decouples classification from reconstruction
// ---------------------------------------------------------------------------
`default_nettype none

module psuf_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  psuf_pkg::queue_entry_t      push_entry,
  output logic                        push_ready,
  input  wire logic                   pop,
  output logic                        pop_valid,
  output psuf_pkg::queue_entry_t      head
);

  psuf_pkg::queue_entry_t          entries [psuf_pkg::QUEUE_DEPTH];
  logic [psuf_pkg::QPTR_W-1:0]     wptr;
  logic [psuf_pkg::QPTR_W-1:0]     rptr;
  logic [psuf_pkg::QCNT_W-1:0]     count;

  assign push_ready = (count != psuf_pkg::QCNT_W'(psuf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + psuf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + psuf_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + psuf_pkg::QCNT_W'(1);
        2'b01:   count <= count - psuf_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psuf_back.sv =====
// ---------------------------------------------------------------------------
// psuf_back
// line memory, pixel history and filter reconstruction with output register
// ---------------------------------------------------------------------------
`default_nettype none

module psuf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [psuf_pkg::PIX_W-1:0]  bpp_idx,
  input  wire logic                        q_valid,
  input  psuf_pkg::queue_entry_t           q_head,
  output logic                             q_pop,
  psuf_pixel_if.source                     pixel_out
);

  logic [7:0]             line_mem [psuf_pkg::LINE_MAX];
  logic [7:0]             above;
  logic [7:0]             left_hist  [psuf_pkg::PIXEL_MAX];
  logic [7:0]             upper_hist [psuf_pkg::PIXEL_MAX];

  logic                   s1_valid;
  psuf_pkg::queue_entry_t s1;
  logic                   s1_fire;
  logic                   s1_result;

  logic                   out_valid;
  logic [7:0]             out_byte;
  logic                   out_last;
  logic                   out_bad;

  logic [7:0]             a;
  logic [7:0]             b;
  logic [7:0]             c;
  logic [7:0]             pred;
  logic [7:0]             recon;

  assign s1_result = (s1.kind != psuf_pkg::KIND_FILTER);
  assign s1_fire   = s1_valid && (!s1_result || !out_valid || pixel_out.ready);
  assign q_pop     = q_valid && (!s1_valid || s1_fire);

  assign a = left_hist[bpp_idx];
  assign c = upper_hist[bpp_idx];
  assign b = s1.first_row ? 8'h00 : above;

  always_comb begin
    case (s1.filter)
      psuf_pkg::FILT_SUB:   pred = a;
      psuf_pkg::FILT_UP:    pred = b;
      psuf_pkg::FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
      psuf_pkg::FILT_PAETH: pred = psuf_pkg::paeth_pick(a, b, c);
      default:              pred = 8'h00;
    endcase
  end

  assign recon = s1.value + pred;

  // row above: read on pop, written when the data transaction leaves stage one
  always_ff @(posedge clk) begin
    if (q_pop) begin
      above <= line_mem[q_head.idx];
    end
    if (s1_fire && s1.kind == psuf_pkg::KIND_DATA) begin
      line_mem[s1.idx] <= recon;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < psuf_pkg::PIXEL_MAX; k++) begin
        left_hist[k]  <= 8'h00;
        upper_hist[k] <= 8'h00;
      end
    end else if (s1_fire) begin
      if (s1.kind == psuf_pkg::KIND_DATA) begin
        for (int k = psuf_pkg::PIXEL_MAX - 1; k > 0; k--) begin
          left_hist[k]  <= left_hist[k-1];
          upper_hist[k] <= upper_hist[k-1];
        end
        left_hist[0]  <= recon;
        upper_hist[0] <= b;
      end else begin
        for (int k = 0; k < psuf_pkg::PIXEL_MAX; k++) begin
          left_hist[k]  <= 8'h00;
          upper_hist[k] <= 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1_result) begin
        out_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      if (s1.kind == psuf_pkg::KIND_BAD_FILTER) begin
        out_byte <= 8'h00;
        out_last <= 1'b0;
        out_bad  <= 1'b1;
      end else begin
        out_byte <= recon;
        out_last <= s1.last;
        out_bad  <= 1'b0;
      end
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_byte  = out_byte;
  assign pixel_out.last_in_row = out_last;
  assign pixel_out.bad_filter  = out_bad;

endmodule

`default_nettype wire

// ===== rtl/png_scanline_unfilter_core.sv =====
// ---------------------------------------------------------------------------
// png_scanline_unfilter_core
// png filter reconstruction (none, sub, up, average, paeth) on a byte stream
// ---------------------------------------------------------------------------
// Takes one inflated byte per cycle and returns one reconstructed byte per
// cycle for every data byte, unless stalled; the filter byte at each row start
// gives no result unless its code is above 4. Sustained rate is one
// transaction per cycle, set by the line memory, which has one read port and
// one write port: the row above is read when a byte enters reconstruction
// and the rebuilt byte is written when it leaves, once each per byte. Results
// pass the queue, stage one and the output register. A four-entry queue
// separates the row tracking front end from the reconstruction back end, and
// the output register lets input continue while a result waits, until the
// queue is full. The line memory needs no clearing after reset. Write
// bytes_per_line (address 0) and bytes_per_pixel (address 4) only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  psuf_byte_if.sink                         byte_in,
  psuf_pixel_if.source                      pixel_out,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psuf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [psuf_pkg::LEN_W-1:0] bytes_per_line;
  logic [psuf_pkg::BPP_W-1:0] bytes_per_pixel;
  logic [psuf_pkg::LEN_W-1:0] line_len;
  logic [psuf_pkg::BPP_W-1:0] bpp_clamp;
  logic [psuf_pkg::BPP_W-1:0] bpp_less;
  logic [psuf_pkg::PIX_W-1:0] bpp_idx;

  logic                       q_push;
  logic                       q_ready;
  logic                       q_pop;
  logic                       q_valid;
  psuf_pkg::queue_entry_t     q_in;
  psuf_pkg::queue_entry_t     q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_line  <= psuf_pkg::LEN_RESET;
      bytes_per_pixel <= psuf_pkg::BPP_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        psuf_pkg::REG_BYTES_PER_LINE:  bytes_per_line  <= pwdata[psuf_pkg::LEN_W-1:0];
        psuf_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= pwdata[psuf_pkg::BPP_W-1:0];
        default:                       bytes_per_line  <= bytes_per_line;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      psuf_pkg::REG_BYTES_PER_LINE:  prdata = 32'(bytes_per_line);
      psuf_pkg::REG_BYTES_PER_PIXEL: prdata = 32'(bytes_per_pixel);
      default:                       prdata = 32'h0;
    endcase
  end

  // saturate into the supported ranges
  always_comb begin
    if (bytes_per_line == '0) begin
      line_len = psuf_pkg::LEN_W'(1);
    end else if (bytes_per_line > psuf_pkg::LEN_RESET) begin
      line_len = psuf_pkg::LEN_RESET;
    end else begin
      line_len = bytes_per_line;
    end
    if (bytes_per_pixel == '0) begin
      bpp_clamp = psuf_pkg::BPP_W'(1);
    end else if (bytes_per_pixel > psuf_pkg::BPP_RESET) begin
      bpp_clamp = psuf_pkg::BPP_RESET;
    end else begin
      bpp_clamp = bytes_per_pixel;
    end
  end

  assign bpp_less = bpp_clamp - psuf_pkg::BPP_W'(1);
  assign bpp_idx  = bpp_less[psuf_pkg::PIX_W-1:0];

  psuf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .line_len (line_len),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  psuf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .head       (q_head)
  );

  psuf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .bpp_idx   (bpp_idx),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pixel_out (pixel_out)
  );

endmodule

`default_nettype wire

// ===== rtl/psuf_checker.sv =====
// ---------------------------------------------------------------------------
// psuf_checker
// port-level checks on the unfilter core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "png_scanline_unfilter_core_defines.svh"

module psuf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] pixel_byte,
  input wire logic       last_in_row,
  input wire logic       bad_filter
);

  `PSUF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `PSUF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(pixel_byte) && $stable(last_in_row) && $stable(bad_filter), "result changed while stalled")

  `PSUF_ASSERT(a_bad_clean, clk, rst, (out_valid && bad_filter) |-> (pixel_byte == 8'h00 && !last_in_row), "bad filter result carries data")

  `PSUF_ASSERT(a_reset_quiet, clk, rst, $past(rst) |-> !out_valid, "result right after reset")

  `PSUF_ASSERT_NEXT(a_no_phantom, clk, rst, !out_valid && !$past(in_valid && in_ready) && !(in_valid && in_ready) && $past(rst), !out_valid, "result without transaction after reset")

endmodule

bind png_scanline_unfilter_core psuf_checker u_psuf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (byte_in.valid),
  .in_ready    (byte_in.ready),
  .out_valid   (pixel_out.valid),
  .out_ready   (pixel_out.ready),
  .pixel_byte  (pixel_out.pixel_byte),
  .last_in_row (pixel_out.last_in_row),
  .bad_filter  (pixel_out.bad_filter)
);

`default_nettype wire

// ===== sim/png_scanline_unfilter_core_tb.sv =====
// ---------------------------------------------------------------------------
// png_scanline_unfilter_core_tb
// self-checking bench for the png scan-line unfilter core
// ---------------------------------------------------------------------------
// Feeds inflated bytes through the input channel and predicts every
// reconstructed byte from its own line memory, pixel history and row
// tracking. A short directed part covers each filter type, byte extremes,
// bad filter codes, a start mark inside a row and a line length lowered
// inside a row. Random phases then change the geometry through the
// register port and send mostly well-formed rows with random content, with
// some bad filters, truncated rows and rows cut at a phase boundary. Both
// channels idle and stall at random; a watchdog ends a hung run.
// ---------------------------------------------------------------------------
module png_scanline_unfilter_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int ITEM_COUNT     = 1050;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       bad_filter;
  } pixel_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [psuf_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  psuf_byte_if  byte_ch ();
  psuf_pixel_if pixel_ch ();

  png_scanline_unfilter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .pixel_out (pixel_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  byte_item_t pending_bytes[$];
  pixel_t     expected_pixels[$];
  byte_item_t drive_item;
  int         bytes_queued;
  int         bytes_taken;
  int         errors;
  int         cycle_count;
  int         quiet_cycles;
  logic       force_start;

  logic [psuf_pkg::LEN_W-1:0] cfg_len;
  logic [psuf_pkg::BPP_W-1:0] cfg_bpp;
  logic [7:0]                 line_above [psuf_pkg::LINE_MAX];
  logic [7:0]                 left_hist [psuf_pkg::PIXEL_MAX];
  logic [7:0]                 upleft_hist [psuf_pkg::PIXEL_MAX];
  psuf_pkg::filter_t          cur_filter;
  logic [psuf_pkg::LEN_W-1:0] row_pos;
  logic                       in_first_row;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int line_length(input logic [psuf_pkg::LEN_W-1:0] raw);
    if (raw == 0) return 1;
    if (int'(raw) > psuf_pkg::LINE_MAX) return psuf_pkg::LINE_MAX;
    return int'(raw);
  endfunction

  function automatic int pixel_distance(input logic [psuf_pkg::BPP_W-1:0] raw);
    if (raw == 0) return 1;
    if (int'(raw) > psuf_pkg::PIXEL_MAX) return psuf_pkg::PIXEL_MAX;
    return int'(raw);
  endfunction

  function automatic logic [7:0] paeth_nearest(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    int estimate;
    int dist_a;
    int dist_b;
    int dist_c;
    estimate = int'(a) + int'(b) - int'(c);
    dist_a = (estimate > int'(a)) ? estimate - int'(a) : int'(a) - estimate;
    dist_b = (estimate > int'(b)) ? estimate - int'(b) : int'(b) - estimate;
    dist_c = (estimate > int'(c)) ? estimate - int'(c) : int'(c) - estimate;
    if (dist_a <= dist_b && dist_a <= dist_c) return a;
    if (dist_b <= dist_c) return b;
    return c;
  endfunction

  task automatic unfilter_step(input logic [7:0] v, input logic start);
    int         len_eff;
    int         bpp_eff;
    int         idx;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] pred;
    logic [8:0] pair_sum;
    logic [7:0] r;
    logic       last;
    if (start) begin
      row_pos = '0;
      in_first_row = 1'b1;
    end
    if (row_pos == 0) begin
      for (int k = 0; k < psuf_pkg::PIXEL_MAX; k++) begin
        left_hist[k] = 8'h00;
        upleft_hist[k] = 8'h00;
      end
      row_pos = psuf_pkg::LEN_W'(1);
      if (v > psuf_pkg::FILTER_CODE_MAX) begin
        cur_filter = psuf_pkg::FILT_NONE;
        expected_pixels.push_back('{pixel_byte: 8'h00, last_in_row: 1'b0, bad_filter: 1'b1});
      end else begin
        cur_filter = psuf_pkg::filter_t'(v[2:0]);
      end
      return;
    end
    len_eff = line_length(cfg_len);
    bpp_eff = pixel_distance(cfg_bpp);
    idx = int'(row_pos) - 1;
    a = left_hist[bpp_eff-1];
    c = upleft_hist[bpp_eff-1];
    b = in_first_row ? 8'h00 : line_above[idx];
    pair_sum = {1'b0, a} + {1'b0, b};
    case (cur_filter)
      psuf_pkg::FILT_SUB:   pred = a;
      psuf_pkg::FILT_UP:    pred = b;
      psuf_pkg::FILT_AVG:   pred = pair_sum[8:1];
      psuf_pkg::FILT_PAETH: pred = paeth_nearest(a, b, c);
      default:              pred = 8'h00;
    endcase
    r = v + pred;
    line_above[idx] = r;
    for (int k = psuf_pkg::PIXEL_MAX - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0] = r;
    upleft_hist[0] = b;
    last = (idx + 1 >= len_eff);
    if (last) begin
      row_pos = '0;
      in_first_row = 1'b0;
    end else begin
      row_pos = row_pos + 1'b1;
    end
    expected_pixels.push_back('{pixel_byte: r, last_in_row: last, bad_filter: 1'b0});
  endtask

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.byte_value <= 8'h00;
      byte_ch.start_image <= 1'b0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (pending_bytes.size() != 0 &&
          ((cycle_count >= 500 && cycle_count < 1000) || $urandom_range(0, 99) >= 10)) begin
        drive_item = pending_bytes.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.byte_value <= drive_item.value;
        byte_ch.start_image <= drive_item.start;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= (cycle_count >= 500 && cycle_count < 1000) ||
                        ($urandom_range(0, 99) >= 10);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        unfilter_step(byte_ch.byte_value, byte_ch.start_image);
        bytes_taken++;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected transaction: byte %02h last %0b bad %0b",
                                  pixel_ch.pixel_byte, pixel_ch.last_in_row,
                                  pixel_ch.bad_filter));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_ch.pixel_byte !== want.pixel_byte ||
              pixel_ch.last_in_row !== want.last_in_row ||
              pixel_ch.bad_filter !== want.bad_filter) begin
            note_mismatch($sformatf({"pixel mismatch: expected byte %02h last %0b bad %0b,",
                                     " got byte %02h last %0b bad %0b"},
                                    want.pixel_byte, want.last_in_row, want.bad_filter,
                                    pixel_ch.pixel_byte, pixel_ch.last_in_row,
                                    pixel_ch.bad_filter));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (byte_ch.valid && byte_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] random_data();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 8'h00;
    if (pick < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(input logic [7:0] v, input logic start);
    pending_bytes.push_back('{value: v, start: start | force_start});
    force_start = 1'b0;
    bytes_queued++;
  endtask

  task automatic send_row(input logic [7:0] filter, input int n, input logic start);
    send(filter, start);
    repeat (n) send(random_data(), 1'b0);
  endtask

  task automatic send_triple(input logic [7:0] filter, input logic start, input logic [7:0] d0,
                             input logic [7:0] d1, input logic [7:0] d2);
    send(filter, start);
    send(d0, 1'b0);
    send(d1, 1'b0);
    send(d2, 1'b0);
  endtask

  task automatic settle();
    while (bytes_taken != bytes_queued || expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_idx == psuf_pkg::REG_BYTES_PER_LINE) cfg_len = value[psuf_pkg::LEN_W-1:0];
    else cfg_bpp = value[psuf_pkg::BPP_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // a longer line would read row-above bytes never written in this image
  task automatic configure(input logic [psuf_pkg::LEN_W-1:0] len_raw,
                           input logic [psuf_pkg::BPP_W-1:0] bpp_raw);
    int          old_len;
    logic [31:0] word;
    settle();
    old_len = line_length(cfg_len);
    word = $urandom();
    word[psuf_pkg::LEN_W-1:0] = len_raw;
    write_reg(psuf_pkg::REG_BYTES_PER_LINE, word);
    word = $urandom();
    word[psuf_pkg::BPP_W-1:0] = bpp_raw;
    write_reg(psuf_pkg::REG_BYTES_PER_PIXEL, word);
    if (line_length(len_raw) > old_len) force_start = 1'b1;
  endtask

  initial begin
    int pick;
    int ln;
    int rows;
    int n;
    logic [psuf_pkg::LEN_W-1:0] len_raw;
    logic [7:0] filter;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.byte_value = 8'h00;
    byte_ch.start_image = 1'b0;
    pixel_ch.ready = 1'b0;
    bytes_queued = 0;
    bytes_taken = 0;
    errors = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    force_start = 1'b1;
    cfg_len = psuf_pkg::LEN_RESET;
    cfg_bpp = psuf_pkg::BPP_RESET;
    cur_filter = psuf_pkg::FILT_NONE;
    row_pos = '0;
    in_first_row = 1'b1;
    for (int k = 0; k < psuf_pkg::PIXEL_MAX; k++) begin
      left_hist[k] = 8'h00;
      upleft_hist[k] = 8'h00;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every filter type, byte extremes, bad filter codes
    configure(13'd3, 3'd1);
    send_triple(psuf_pkg::FILT_NONE, 1'b1, 8'h00, 8'hFF, 8'h80);
    send_triple(psuf_pkg::FILT_SUB, 1'b0, 8'hFF, 8'h01, 8'h7F);
    send_triple(psuf_pkg::FILT_UP, 1'b0, 8'h01, 8'hFF, 8'h00);
    send_triple(psuf_pkg::FILT_AVG, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_triple(psuf_pkg::FILT_PAETH, 1'b0, 8'h00, 8'h00, 8'h10);
    send_triple(8'hFF, 1'b0, 8'h12, 8'h34, 8'h56);
    // start mark inside a row
    send(psuf_pkg::FILT_PAETH, 1'b0);
    send(8'hF0, 1'b0);
    send_triple(8'd5, 1'b1, 8'hA5, 8'h5A, 8'hC3);
    send_triple(psuf_pkg::FILT_UP, 1'b0, 8'h80, 8'h7F, 8'h01);
    // line length lowered inside a row
    configure(13'd8, 3'd2);
    send_row(psuf_pkg::FILT_SUB, 5, 1'b0);
    configure(13'd3, 3'd2);
    send(random_data(), 1'b0);
    send_triple(psuf_pkg::FILT_PAETH, 1'b0, 8'hFE, 8'h02, 8'h80);
    // register extremes
    configure(13'd0, 3'd0);
    send_row(psuf_pkg::FILT_SUB, 1, 1'b0);
    send_row(psuf_pkg::FILT_UP, 1, 1'b0);
    send_row(psuf_pkg::FILT_AVG, 1, 1'b0);
    configure(13'h1FFF, 3'd7);
    send_row(psuf_pkg::FILT_SUB, 20, 1'b0);
    force_start = 1'b1;
    configure(13'(psuf_pkg::LINE_MAX), 3'(psuf_pkg::PIXEL_MAX));
    send_row(psuf_pkg::FILT_PAETH, 20, 1'b0);
    force_start = 1'b1;

    while (bytes_queued < ITEM_COUNT) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len_raw = 13'd0;
      else if (pick < 12) len_raw = 13'($urandom_range(40, 120));
      else len_raw = 13'($urandom_range(1, 24));
      configure(len_raw, 3'($urandom_range(0, 7)));
      ln = line_length(len_raw);
      rows = (ln > 24) ? $urandom_range(1, 3) : $urandom_range(3, 10);
      repeat (rows) begin
        if ($urandom_range(0, 99) < 10) filter = 8'($urandom_range(5, 255));
        else filter = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 6) begin
          send_row(filter, $urandom_range(0, ln - 1), $urandom_range(0, 99) < 8);
          force_start = 1'b1;
        end else begin
          send_row(filter, ln, $urandom_range(0, 99) < 8);
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 4);
        send_row(8'($urandom_range(0, 4)), n, 1'b0);
      end
    end

    settle();
    errors += expected_pixels.size();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
